@@ src/battery_alarm_monitor_core_defines.svh @@
// ----------------------------------------------------------------------------
// Battery alarm monitor assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_ALARM_MONITOR_CORE_DEFINES_SVH
`define BATTERY_ALARM_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication
`define BAM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bam_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery alarm monitor package
// Alarm state codes, register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package bam_pkg;

    localparam int unsigned VAL_W     = 16;
    localparam int unsigned STATE_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned IN_DATA_W  = 40;  // 35 bits of fields, zero filled
    localparam int unsigned OUT_DATA_W = 8;   // 7 bits of fields, zero filled

    typedef logic [STATE_W-1:0]   alm_state_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [VAL_W-1:0]     cfg_data_t;
    typedef logic [IN_DATA_W-1:0]  in_data_t;
    typedef logic [OUT_DATA_W-1:0] out_data_t;

    // Alarm states
    localparam alm_state_t ALM_CLEAR  = 2'd0;
    localparam alm_state_t ALM_ACTIVE = 2'd1;
    localparam alm_state_t ALM_ACKED  = 2'd2;

    // Register indexes
    localparam cfg_idx_t REG_CURRENT_TRIP_LOW  = 3'd0;
    localparam cfg_idx_t REG_CURRENT_TRIP_HIGH = 3'd1;
    localparam cfg_idx_t REG_CURRENT_CLEAR_LOW = 3'd2;
    localparam cfg_idx_t REG_VOLTAGE_LOW       = 3'd3;
    localparam cfg_idx_t REG_VOLTAGE_HIGH      = 3'd4;

    // Register reset values
    localparam logic signed [VAL_W-1:0] CURRENT_TRIP_LOW_RST  = -16'sd80;
    localparam logic signed [VAL_W-1:0] CURRENT_TRIP_HIGH_RST = 16'sd320;
    localparam logic signed [VAL_W-1:0] CURRENT_CLEAR_LOW_RST = 16'sd80;
    localparam logic [VAL_W-1:0]        VOLTAGE_LOW_RST       = 16'd4480;
    localparam logic [VAL_W-1:0]        VOLTAGE_HIGH_RST      = 16'd6480;

endpackage

@@ src/battery_alarm_monitor_core.sv @@
// ----------------------------------------------------------------------------
// Battery alarm monitor core
// Interlock, overcurrent and voltage window alarms with acknowledge.
// ----------------------------------------------------------------------------
// One sample per cycle, sustained while m_tready is high. A sample is
// captured in an input register, the alarm states are updated from it, and
// the result is held in an output register. The rate is set by the update
// of the alarm state registers. With the output stalled, one further sample
// is still taken into the input register. The user must write registers on
// the cfg channel only while no sample is in flight; the block does not
// enforce this. cfg_ready is always high.
`include "battery_alarm_monitor_core_defines.svh"

module battery_alarm_monitor_core (
    input  logic                 clk,
    input  logic                 rst_n,
    // stream in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] skip, [1] interlock_ok, [17:2] pack_current, [33:18] pack_voltage,
    // [34] acknowledge, [39:35] zero
    input  bam_pkg::in_data_t    s_tdata,
    // stream out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] interlock_state, [3:2] current_state, [5:4] voltage_state,
    // [6] any_alarm, [7] zero
    output bam_pkg::out_data_t   m_tdata,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  bam_pkg::cfg_idx_t    cfg_index,
    input  bam_pkg::cfg_data_t   cfg_data
);
    import bam_pkg::*;

    // configuration registers
    logic signed [VAL_W-1:0] cur_trip_low_reg;
    logic signed [VAL_W-1:0] cur_trip_high_reg;
    logic signed [VAL_W-1:0] cur_clear_low_reg;
    logic [VAL_W-1:0]        volt_low_reg;
    logic [VAL_W-1:0]        volt_high_reg;

    // input stage
    logic     in_valid_reg;
    in_data_t in_data_reg;

    // alarm state
    alm_state_t il_state_reg, il_state_next;
    alm_state_t cur_state_reg, cur_state_next;
    alm_state_t volt_state_reg, volt_state_next;
    logic       il_pend_reg, il_pend_next;
    logic       cur_pend_reg, cur_pend_next;
    logic       volt_pend_reg, volt_pend_next;
    logic       combined_reg, combined_next;

    // output stage
    logic      out_valid_reg;
    out_data_t out_data_reg;

    logic                    advance;
    logic                    skip;
    logic                    ilk_ok;
    logic signed [VAL_W-1:0] cur;
    logic [VAL_W-1:0]        volt;
    logic                    ack;
    logic                    cur_out, cur_in, volt_out, volt_in;
    alm_state_t              cur_state_w, volt_state_w;
    logic                    cur_pend_w, volt_pend_w;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign skip   = in_data_reg[0];
    assign ilk_ok = in_data_reg[1];
    assign cur    = $signed(in_data_reg[17:2]);
    assign volt   = in_data_reg[33:18];
    assign ack    = in_data_reg[34];

    assign cur_out  = (cur < cur_trip_low_reg) || (cur > cur_trip_high_reg);
    assign cur_in   = (cur > cur_clear_low_reg) && (cur < cur_trip_high_reg);
    assign volt_out = (volt < volt_low_reg) || (volt > volt_high_reg);
    assign volt_in  = (volt > volt_low_reg) && (volt < volt_high_reg);

    // Raise from clear, promote to acknowledged once the flag is gone,
    // then drop back to clear when strictly inside the clear window.
    always_comb
    begin
        cur_state_w = cur_state_reg;
        cur_pend_w  = cur_pend_reg;
        case (cur_state_reg)
            ALM_CLEAR:
            begin
                if (cur_out)
                begin
                    cur_state_w = ALM_ACTIVE;
                    cur_pend_w  = 1'b1;
                end
            end
            ALM_ACTIVE:
            begin
                if (!cur_pend_reg)
                    cur_state_w = ALM_ACKED;
            end
            default: ;
        endcase
        if (cur_in)
        begin
            cur_state_w = ALM_CLEAR;
            cur_pend_w  = 1'b0;
        end

        volt_state_w = volt_state_reg;
        volt_pend_w  = volt_pend_reg;
        case (volt_state_reg)
            ALM_CLEAR:
            begin
                if (volt_out)
                begin
                    volt_state_w = ALM_ACTIVE;
                    volt_pend_w  = 1'b1;
                end
            end
            ALM_ACTIVE:
            begin
                if (!volt_pend_reg)
                    volt_state_w = ALM_ACKED;
            end
            default: ;
        endcase
        if (volt_in)
        begin
            volt_state_w = ALM_CLEAR;
            volt_pend_w  = 1'b0;
        end
    end

    always_comb
    begin
        il_state_next   = il_state_reg;
        il_pend_next    = il_pend_reg;
        cur_state_next  = cur_state_reg;
        cur_pend_next   = cur_pend_reg;
        volt_state_next = volt_state_reg;
        volt_pend_next  = volt_pend_reg;
        combined_next   = combined_reg;
        if (!skip)
        begin
            if (!ilk_ok && il_state_reg == ALM_CLEAR)
            begin
                il_state_next = ALM_ACTIVE;
                il_pend_next  = 1'b1;
            end
            else if (!ilk_ok)
            begin
                il_state_next = il_pend_reg ? ALM_ACTIVE : ALM_ACKED;
            end
            else
            begin
                il_state_next = ALM_CLEAR;
                il_pend_next  = 1'b0;
            end
            cur_state_next  = cur_state_w;
            cur_pend_next   = cur_pend_w;
            volt_state_next = volt_state_w;
            volt_pend_next  = volt_pend_w;
            // acknowledge lands after the state update
            if (ack)
            begin
                il_pend_next   = 1'b0;
                cur_pend_next  = 1'b0;
                volt_pend_next = 1'b0;
            end
            combined_next = il_pend_next || cur_pend_next || volt_pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_trip_low_reg  <= CURRENT_TRIP_LOW_RST;
            cur_trip_high_reg <= CURRENT_TRIP_HIGH_RST;
            cur_clear_low_reg <= CURRENT_CLEAR_LOW_RST;
            volt_low_reg      <= VOLTAGE_LOW_RST;
            volt_high_reg     <= VOLTAGE_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CURRENT_TRIP_LOW:  cur_trip_low_reg  <= $signed(cfg_data);
                REG_CURRENT_TRIP_HIGH: cur_trip_high_reg <= $signed(cfg_data);
                REG_CURRENT_CLEAR_LOW: cur_clear_low_reg <= $signed(cfg_data);
                REG_VOLTAGE_LOW:       volt_low_reg      <= cfg_data;
                REG_VOLTAGE_HIGH:      volt_high_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            il_state_reg   <= ALM_CLEAR;
            cur_state_reg  <= ALM_CLEAR;
            volt_state_reg <= ALM_CLEAR;
            il_pend_reg    <= 1'b0;
            cur_pend_reg   <= 1'b0;
            volt_pend_reg  <= 1'b0;
            combined_reg   <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                il_state_reg   <= il_state_next;
                cur_state_reg  <= cur_state_next;
                volt_state_reg <= volt_state_next;
                il_pend_reg    <= il_pend_next;
                cur_pend_reg   <= cur_pend_next;
                volt_pend_reg  <= volt_pend_next;
                combined_reg   <= combined_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
        if (advance)
            out_data_reg <= {1'b0, combined_next, volt_state_next,
                             cur_state_next, il_state_next};
    end

    `BAM_ASSERT_NOW(a_pend_implies_active,
        il_pend_reg || cur_pend_reg || volt_pend_reg,
        (!il_pend_reg || il_state_reg == ALM_ACTIVE) &&
        (!cur_pend_reg || cur_state_reg == ALM_ACTIVE) &&
        (!volt_pend_reg || volt_state_reg == ALM_ACTIVE),
        "pending flag set on an alarm that is not active unacknowledged")

    `BAM_ASSERT_NOW(a_combined_matches,
        1'b1,
        combined_reg == (il_pend_reg || cur_pend_reg || volt_pend_reg),
        "combined alarm differs from the OR of the pending flags")

    `BAM_ASSERT_NEXT(a_state_holds_on_stall,
        in_valid_reg && !advance,
        in_valid_reg && $stable(il_state_reg) && $stable(cur_state_reg) &&
        $stable(volt_state_reg) && $stable(combined_reg),
        "alarm state moved while the held sample was stalled")

endmodule
